>>> design/sccon_pkg.sv
package sccon_pkg;

  // field widths
  localparam int CW  = 32;             // coordinate, Q16.16
  localparam int UF  = 14;             // unit vector fraction bits
  localparam int AW  = UF + 2;         // unit vector width
  localparam int LW  = CW - 2;         // lengths and radii
  localparam int DW  = CW - 1;         // depth
  localparam int NG  = 14;             // guard bits of the normalising root

  localparam longint ONE  = 64'(1) << UF;
  localparam longint HALF = ONE / 2;

  // internal widths
  localparam int PRW = CW + AW;        // offset * axis
  localparam int PW  = PRW + 2;        // dot product
  localparam int TW  = LW + 1;         // clamped projection, signed
  localparam int ARW = 2 * AW;         // axis * axis
  localparam int CTW = AW + TW;        // axis * projection
  localparam int CCW = CW + 1;         // segment point
  localparam int CDW = CCW + 1;        // segment point + offset
  localparam int DLW = CW + 2;         // offset to segment
  localparam int PPW = AW + 3;         // fallback vector
  localparam int SQW = 2 * DLW;
  localparam int PQW = 2 * PPW;
  localparam int D2W = SQW + 2;        // squared distance
  localparam int RSW = LW + 1;         // radius sum
  localparam int SX  = D2W + 2 * NG;   // root operand
  localparam int RW  = SX / 2;         // root width
  localparam int QB  = UF + 1;         // quotient bits of the normal
  localparam int DVW = RW + UF + 1;    // divider remainder
  localparam int LNW = RW - NG + 1;    // rounded distance
  localparam int MPW = AW + RSW;       // normal * radius difference
  localparam int MW  = CDW + UF + 1;   // contact numerator

  // queue
  localparam int QDEPTH = 16;
  localparam int QAW    = 4;
  localparam int FS     = 7;           // items that can be in the front at once
  localparam int QBUSY  = QDEPTH - FS;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // front pipeline item
  typedef struct packed {
    logic [2:0][CW-1:0]  d;
    logic [2:0][AW-1:0]  a;
    logic [LW-1:0]       h;
    logic [LW-1:0]       rc;
    logic [LW-1:0]       rs;
    logic                sf;
    logic [2:0][PRW-1:0] pr;
    logic [TW-1:0]       t;
    logic [1:0]          r;
    logic [2:0][ARW-1:0] ar;
    logic [2:0][CTW-1:0] ct;
    logic [2:0][PPW-1:0] pp;
    logic [2:0][DLW-1:0] dl;
    logic [2:0][CDW-1:0] cd;
    logic [2:0][SQW-1:0] sq;
    logic [2:0][PQW-1:0] pq;
    logic [RSW-1:0]      rsum;
    logic [2*RSW-1:0]    rs2;
  } fi_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                hit;
    logic                sf;
    logic                d2nz;
    logic                px;
    logic [2:0][DLW-1:0] v;
    logic [D2W-1:0]      x;
    logic [2:0][CDW-1:0] cd;
    logic [LW-1:0]       rc;
    logic [LW-1:0]       rs;
    logic [RSW-1:0]      rsum;
  } qi_t;

  typedef struct packed {
    logic busy;
    logic [QAW:0] fill;
  } qstat_t;

endpackage

>>> design/sccon_front.sv
module sccon_front import sccon_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic signed [CW-1:0] offset_x,
  input  logic signed [CW-1:0] offset_y,
  input  logic signed [CW-1:0] offset_z,
  input  logic signed [AW-1:0] axis_x,
  input  logic signed [AW-1:0] axis_y,
  input  logic signed [AW-1:0] axis_z,
  input  logic [LW-1:0]        half_length,
  input  logic [LW-1:0]        capsule_radius,
  input  logic [LW-1:0]        sphere_radius,
  input  logic                 sphere_is_first,
  output logic                 push,
  output qi_t                  push_item
);

  fi_t s0_r, s1_r, s2_r, s3_r, s4_r, s5_r;
  fi_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt;
  logic [5:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[4:0], acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_r <= '{d: {offset_z, offset_y, offset_x},
                a: {axis_z, axis_y, axis_x},
                h: half_length,
                rc: capsule_radius,
                rs: sphere_radius,
                sf: sphere_is_first,
                default: '0};
    end
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
    s5_r <= s5_nxt;
  end

  // offset * axis products
  always_comb begin
    logic signed [PRW-1:0] m;
    s1_nxt = s0_r;
    for (int i = 0; i < 3; i++) begin
      m = $signed(s0_r.d[i]) * $signed(s0_r.a[i]);
      s1_nxt.pr[i] = m;
    end
  end

  // projection, clamp; least aligned basis axis for the fallback normal
  always_comb begin
    logic signed [PW-1:0] p;
    logic [PW-1:0] pm, hone, tr;
    logic [LW-1:0] tm;
    logic neg;
    logic [2:0][AW-1:0] am;
    logic [AW-1:0] best;
    logic [1:0] r;
    logic signed [ARW-1:0] m;
    s2_nxt = s1_r;
    p = $signed(s1_r.pr[0]) + $signed(s1_r.pr[1]) + $signed(s1_r.pr[2]);
    neg = p[PW-1];
    pm = neg ? -p : p;
    hone = {{(PW - LW - UF){1'b0}}, s1_r.h, {UF{1'b0}}};
    tr = (pm + PW'(HALF)) >> UF;
    tm = (pm >= hone) ? s1_r.h : tr[LW-1:0];
    s2_nxt.t = neg ? (~{1'b0, tm} + 1'b1) : {1'b0, tm};
    for (int i = 0; i < 3; i++) begin
      am[i] = s1_r.a[i][AW-1] ? -s1_r.a[i] : s1_r.a[i];
    end
    r = 2'd0;
    best = am[0];
    if (am[1] < best) begin
      r = 2'd1;
      best = am[1];
    end
    if (am[2] < best) begin
      r = 2'd2;
    end
    s2_nxt.r = r;
    for (int i = 0; i < 3; i++) begin
      m = $signed(s1_r.a[i]) * $signed(s1_r.a[r]);
      s2_nxt.ar[i] = m;
    end
  end

  // axis * t, fallback vector
  always_comb begin
    logic signed [CTW-1:0] m;
    logic [ARW-1:0] rm, rq;
    logic signed [ARW-1:0] rnd, pf;
    s3_nxt = s2_r;
    for (int i = 0; i < 3; i++) begin
      m = $signed(s2_r.a[i]) * $signed(s2_r.t);
      s3_nxt.ct[i] = m;
      rm = s2_r.ar[i][ARW-1] ? -s2_r.ar[i] : s2_r.ar[i];
      rq = (rm + ARW'(HALF)) >> UF;
      rnd = s2_r.ar[i][ARW-1] ? -rq : rq;
      pf = ((s2_r.r == 2'(i)) ? ARW'(ONE) : '0) - rnd;
      s3_nxt.pp[i] = pf[PPW-1:0];
    end
  end

  // closest segment point, offset to it
  always_comb begin
    logic [CTW-1:0] cm, cq, cs;
    logic signed [CCW-1:0] cc;
    logic signed [DLW-1:0] dl;
    logic signed [CDW-1:0] cd;
    s4_nxt = s3_r;
    for (int i = 0; i < 3; i++) begin
      cm = s3_r.ct[i][CTW-1] ? -s3_r.ct[i] : s3_r.ct[i];
      cq = (cm + CTW'(HALF)) >> UF;
      cs = s3_r.ct[i][CTW-1] ? -cq : cq;
      cc = cs[CCW-1:0];
      dl = $signed(s3_r.d[i]) - cc;
      cd = $signed(s3_r.d[i]) + cc;
      s4_nxt.dl[i] = dl;
      s4_nxt.cd[i] = cd;
    end
  end

  // squares, radius sum
  always_comb begin
    logic [DLW-1:0] dm;
    logic [PPW-1:0] pm;
    s5_nxt = s4_r;
    for (int i = 0; i < 3; i++) begin
      dm = s4_r.dl[i][DLW-1] ? -s4_r.dl[i] : s4_r.dl[i];
      pm = s4_r.pp[i][PPW-1] ? -s4_r.pp[i] : s4_r.pp[i];
      s5_nxt.sq[i] = dm * dm;
      s5_nxt.pq[i] = pm * pm;
    end
    s5_nxt.rsum = {1'b0, s4_r.rc} + {1'b0, s4_r.rs};
    s5_nxt.rs2 = s5_nxt.rsum * s5_nxt.rsum;
  end

  // contact test and choice of the vector to normalise
  always_comb begin
    logic [D2W-1:0] dist2, plen2;
    logic signed [DLW-1:0] pe;
    dist2 = D2W'(s5_r.sq[0]) + D2W'(s5_r.sq[1]) + D2W'(s5_r.sq[2]);
    plen2 = D2W'(s5_r.pq[0]) + D2W'(s5_r.pq[1]) + D2W'(s5_r.pq[2]);
    push_item.hit  = dist2 <= D2W'(s5_r.rs2);
    push_item.sf   = s5_r.sf;
    push_item.d2nz = dist2 != '0;
    push_item.px   = (dist2 == '0) && ((s5_r.h == '0) || (plen2 == '0));
    push_item.x    = (dist2 != '0) ? dist2 : plen2;
    for (int i = 0; i < 3; i++) begin
      pe = $signed(s5_r.pp[i]);
      push_item.v[i] = (dist2 != '0) ? s5_r.dl[i] : pe;
    end
    push_item.cd   = s5_r.cd;
    push_item.rc   = s5_r.rc;
    push_item.rs   = s5_r.rs;
    push_item.rsum = s5_r.rsum;
  end

  assign push = vld_r[5];

endmodule

>>> design/sccon_fifo.sv
module sccon_fifo import sccon_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qi_t    din,
  output logic   dout_valid,
  output qi_t    dout,
  output qstat_t stat
);

  qi_t mem [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0] cnt_r, cnt_nxt;
  logic pop;
  logic dv_r;

  assign pop = cnt_r != '0;
  assign cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      dv_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
      dv_r  <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= din;
    end
    if (pop) begin
      dout <= mem[rd_r];
    end
  end

  assign dout_valid = dv_r;
  assign stat.fill  = cnt_r;
  assign stat.busy  = cnt_r >= (QAW+1)'(QBUSY);

endmodule

>>> design/sccon_back.sv
module sccon_back import sccon_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  qi_t                  in_item,
  output logic                 strobe,
  output logic [1:0]           status,
  output logic signed [CW-1:0] contact_x,
  output logic signed [CW-1:0] contact_y,
  output logic signed [CW-1:0] contact_z,
  output logic signed [AW-1:0] normal_x,
  output logic signed [AW-1:0] normal_y,
  output logic signed [AW-1:0] normal_z,
  output logic [DW-1:0]        depth
);

  localparam logic signed [MW-1:0] CMAX = MW'((64'(1) << (CW - 1)) - 1);
  localparam logic signed [MW-1:0] CMIN = -CMAX - 1;

  typedef struct packed {
    qi_t            q;
    logic [SX-1:0]  rem;
    logic [RW-1:0]  root;
  } sq_t;

  typedef struct packed {
    qi_t                 q;
    logic [RW-1:0]       lg;
    logic [2:0][DVW-1:0] rem;
    logic [2:0][QB-1:0]  quo;
  } dv_t;

  typedef struct packed {
    logic                hit;
    logic                sf;
    logic [2:0][AW-1:0]  n;
    logic [2:0][MPW-1:0] mp;
    logic [2:0][CDW-1:0] cd;
    logic [RSW-1:0]      rsum;
    logic [LNW-1:0]      len;
  } fa_t;

  sq_t sq_r [RW];
  dv_t dv_r [QB];
  fa_t fa_r, fa_nxt;
  logic [RW-1:0] sqv_r;
  logic [QB-1:0] dvv_r;
  logic fav_r, fbv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r <= '0;
      dvv_r <= '0;
      fav_r <= 1'b0;
      fbv_r <= 1'b0;
    end else begin
      sqv_r <= {sqv_r[RW-2:0], in_v};
      dvv_r <= {dvv_r[QB-2:0], sqv_r[RW-1]};
      fav_r <= dvv_r[QB-1];
      fbv_r <= fav_r;
    end
  end

  // square root, one result bit a stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = RW - 1 - j;
    sq_t src, dst;
    logic [SX-1:0] trial;
    if (j == 0) begin : g_first
      always_comb begin
        src.q    = in_item;
        src.rem  = {in_item.x, {(2 * NG){1'b0}}};
        src.root = '0;
      end
    end else begin : g_next
      assign src = sq_r[j-1];
    end
    always_comb begin
      trial = (SX'(src.root) << (B + 1)) | (SX'(1) << (2 * B));
      dst = src;
      if (src.rem >= trial) begin
        dst.rem = src.rem - trial;
        dst.root[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      sq_r[j] <= dst;
    end
  end

  // three dividers side by side, one quotient bit a stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = UF - j;
    dv_t src, dst;
    logic [DVW-1:0] dsr;
    if (j == 0) begin : g_first
      always_comb begin
        logic [DLW-1:0] vm;
        src.q   = sq_r[RW-1].q;
        src.lg  = sq_r[RW-1].root;
        src.quo = '0;
        for (int i = 0; i < 3; i++) begin
          vm = sq_r[RW-1].q.v[i][DLW-1] ? -sq_r[RW-1].q.v[i] : sq_r[RW-1].q.v[i];
          src.rem[i] = (DVW'(vm) << (UF + NG)) + DVW'(sq_r[RW-1].root >> 1);
        end
      end
    end else begin : g_next
      assign src = dv_r[j-1];
    end
    always_comb begin
      dsr = DVW'(src.lg) << K;
      dst = src;
      for (int i = 0; i < 3; i++) begin
        if (src.rem[i] >= dsr) begin
          dst.rem[i] = src.rem[i] - dsr;
          dst.quo[i][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      dv_r[j] <= dst;
    end
  end

  // signed normal, radius term, rounded distance
  always_comb begin
    logic [AW-1:0] qz, nn;
    logic signed [RSW-1:0] rd;
    logic signed [MPW-1:0] m;
    logic [RW-1:0] lg;
    fa_nxt.hit  = dv_r[QB-1].q.hit;
    fa_nxt.sf   = dv_r[QB-1].q.sf;
    fa_nxt.cd   = dv_r[QB-1].q.cd;
    fa_nxt.rsum = dv_r[QB-1].q.rsum;
    rd = {1'b0, dv_r[QB-1].q.rc} - {1'b0, dv_r[QB-1].q.rs};
    for (int i = 0; i < 3; i++) begin
      qz = {1'b0, dv_r[QB-1].quo[i]};
      if (dv_r[QB-1].q.px) begin
        nn = (i == 0) ? AW'(ONE) : '0;
      end else begin
        nn = dv_r[QB-1].q.v[i][DLW-1] ? (~qz + 1'b1) : qz;
      end
      m = $signed(nn) * rd;
      fa_nxt.n[i]  = nn;
      fa_nxt.mp[i] = m;
    end
    lg = dv_r[QB-1].lg;
    fa_nxt.len = dv_r[QB-1].q.d2nz ? (LNW'(lg[RW-1:NG]) + LNW'(lg[NG-1])) : '0;
  end

  always_ff @(posedge clk) begin
    fa_r <= fa_nxt;
  end

  // midpoint, saturation, orientation
  always_ff @(posedge clk) begin
    logic signed [MW-1:0] num, val;
    logic [MW-1:0] mag, qv;
    logic [LNW-1:0] dp;
    logic sat;
    logic [2:0][CW-1:0] cv;
    logic [2:0][AW-1:0] nv;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num = $signed(fa_r.cd[i]);
      num = (num <<< UF) + $signed(fa_r.mp[i]);
      mag = num[MW-1] ? -num : num;
      qv = (mag + MW'(ONE)) >> (UF + 1);
      val = num[MW-1] ? -qv : qv;
      if (val > CMAX) begin
        val = CMAX;
        sat = 1'b1;
      end else if (val < CMIN) begin
        val = CMIN;
        sat = 1'b1;
      end
      cv[i] = fa_r.hit ? val[CW-1:0] : '0;
      nv[i] = fa_r.hit ? (fa_r.sf ? -fa_r.n[i] : fa_r.n[i]) : '0;
    end
    dp = LNW'(fa_r.rsum) - fa_r.len;
    contact_x <= cv[0];
    contact_y <= cv[1];
    contact_z <= cv[2];
    normal_x  <= nv[0];
    normal_y  <= nv[1];
    normal_z  <= nv[2];
    depth     <= fa_r.hit ? dp[DW-1:0] : '0;
    if (!fa_r.hit) begin
      status <= ST_NONE;
    end else if (sat) begin
      status <= ST_SAT;
    end else begin
      status <= ST_HIT;
    end
  end

  assign strobe = fbv_r;

endmodule

>>> design/sphere_capsule_contact_top.sv
// Throughput: one pair per clock while busy is low; every stage is pipelined,
//   the 49-step square root and the 15-step normal dividers included.
// Reset: synchronous, active low; clears the valid chains and the queue pointers and count only.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sphere_capsule_contact_top import sccon_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_offset_x,
  input  logic signed [CW-1:0] in_offset_y,
  input  logic signed [CW-1:0] in_offset_z,
  input  logic signed [AW-1:0] in_axis_x,
  input  logic signed [AW-1:0] in_axis_y,
  input  logic signed [AW-1:0] in_axis_z,
  input  logic [LW-1:0]        in_half_length,
  input  logic [LW-1:0]        in_capsule_radius,
  input  logic [LW-1:0]        in_sphere_radius,
  input  logic                 in_sphere_is_first,
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic signed [CW-1:0] out_contact_x,
  output logic signed [CW-1:0] out_contact_y,
  output logic signed [CW-1:0] out_contact_z,
  output logic signed [AW-1:0] out_normal_x,
  output logic signed [AW-1:0] out_normal_y,
  output logic signed [AW-1:0] out_normal_z,
  output logic [DW-1:0]        out_depth
);

  // Front: projection onto the axis, clamp, closest segment point, squared
  // distance and the contact test; also builds the fallback vector for a
  // sphere centre sitting on the segment. Six register stages.
  // Queue: decouples front from back. The back drains it every cycle, so in
  // normal use it holds at most one entry; busy is a credit check that keeps
  // room for everything the front can still have in flight.
  // Back: pipelined square root of the guarded squared length, three dividers
  // for the unit normal, then the midpoint of the surface points with
  // saturation and orientation by pair order.

  logic   acc;
  logic   push;
  qi_t    push_item;
  logic   q_valid;
  qi_t    q_item;
  qstat_t q_stat;

  assign busy = q_stat.busy;
  assign acc  = start & ~q_stat.busy;   // an input transfer

  sccon_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (acc),
    .offset_x        (in_offset_x),
    .offset_y        (in_offset_y),
    .offset_z        (in_offset_z),
    .axis_x          (in_axis_x),
    .axis_y          (in_axis_y),
    .axis_z          (in_axis_z),
    .half_length     (in_half_length),
    .capsule_radius  (in_capsule_radius),
    .sphere_radius   (in_sphere_radius),
    .sphere_is_first (in_sphere_is_first),
    .push            (push),
    .push_item       (push_item)
  );

  sccon_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din        (push_item),
    .dout_valid (q_valid),
    .dout       (q_item),
    .stat       (q_stat)
  );

  // Results leave on a strobe; with no contact all fields read zero.
  sccon_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (q_valid),
    .in_item   (q_item),
    .strobe    (out_strobe),
    .status    (out_status),
    .contact_x (out_contact_x),
    .contact_y (out_contact_y),
    .contact_z (out_contact_z),
    .normal_x  (out_normal_x),
    .normal_y  (out_normal_y),
    .normal_z  (out_normal_z),
    .depth     (out_depth)
  );

endmodule

>>> verif/tb.sv
module tb;
  import sccon_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Working width for the contact model: squared distances need ~70 bits,
  // the normalising root operand ~98 bits.
  typedef logic signed [127:0] wide_t;
  typedef logic        [127:0] uwide_t;

  // One pair as presented on the in_ ports.
  typedef struct {
    logic [2:0][CW-1:0] d;     // sphere centre minus capsule centre
    logic [2:0][AW-1:0] a;     // capsule axis
    logic [LW-1:0]      h;     // half segment length
    logic [LW-1:0]      rc;    // capsule radius
    logic [LW-1:0]      rs;    // sphere radius
    logic               sf;    // sphere first in pair order
  } pair_t;

  // One contact report as seen on the out_ ports.
  typedef struct {
    logic [1:0]         status;
    logic [2:0][CW-1:0] c;
    logic [2:0][AW-1:0] n;
    logic [DW-1:0]      depth;
  } contact_t;

  // Directed row: typed = 1 means the expected report is written in the row.
  typedef struct {
    pair_t    p;
    bit       typed;
    contact_t want;
  } row_t;

  localparam int LIMIT = 3000;   // idle cycles before the watchdog fires

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_offset_x = '0, in_offset_y = '0, in_offset_z = '0;
  logic signed [AW-1:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [LW-1:0] in_half_length = '0, in_capsule_radius = '0, in_sphere_radius = '0;
  logic in_sphere_is_first = 1'b0;
  logic out_strobe;
  logic [1:0] out_status;
  logic signed [CW-1:0] out_contact_x, out_contact_y, out_contact_z;
  logic signed [AW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [DW-1:0] out_depth;

  sphere_capsule_contact_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_offset_x(in_offset_x), .in_offset_y(in_offset_y), .in_offset_z(in_offset_z),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_half_length(in_half_length), .in_capsule_radius(in_capsule_radius),
    .in_sphere_radius(in_sphere_radius), .in_sphere_is_first(in_sphere_is_first),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_contact_x(out_contact_x), .out_contact_y(out_contact_y),
    .out_contact_z(out_contact_z),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y), .out_normal_z(out_normal_z),
    .out_depth(out_depth)
  );

  always #5 clk = ~clk;

  contact_t pending_contacts[$];   // reports owed by the block, oldest first
  int       errors = 0;
  int       quiet_cycles = 0;
  int       idle_pct = 0;          // sender gap probability, per cent

  // ---------------------------------------------------------------------------
  // Contact model
  // ---------------------------------------------------------------------------

  // Division rounded to nearest, ties away from zero; den > 0.
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t m, q;
    m = (num < 0) ? -num : num;
    q = (m + (den >>> 1)) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic uwide_t floor_root(uwide_t x);
    uwide_t r, cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (uwide_t'(1) << b);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  // Unit vector in Q2.14 along v; zero vector falls back to +x.
  function automatic void unit_of(input wide_t v[3], output wide_t n[3]);
    uwide_t len2, lg;
    len2 = '0;
    for (int i = 0; i < 3; i++) len2 += uwide_t'(v[i] * v[i]);
    if (len2 == 0) begin
      n[0] = ONE; n[1] = 0; n[2] = 0;
      return;
    end
    lg = floor_root(len2 << (2 * NG));
    for (int i = 0; i < 3; i++) n[i] = div_round(v[i] * (wide_t'(ONE) << NG), wide_t'(lg));
  endfunction

  function automatic contact_t contact_of(pair_t p);
    contact_t res;
    wide_t d[3], a[3], c[3], dl[3], n[3], perp[3];
    wide_t dot, mag, t, rsum, num, v, cmax, cmin;
    uwide_t dist2, len;
    int ref_ax;
    bit sat;
    res.status = ST_NONE;
    res.c = '0;
    res.n = '0;
    res.depth = '0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed(p.d[i]);
      a[i] = $signed(p.a[i]);
      dot += d[i] * a[i];
    end
    // clamp the axial projection to the segment
    mag = (dot < 0) ? -dot : dot;
    if (mag >= wide_t'(p.h) * ONE) t = p.h;
    else t = div_round(mag, ONE);
    if (dot < 0) t = -t;
    dist2 = '0;
    for (int i = 0; i < 3; i++) begin
      c[i] = div_round(a[i] * t, ONE);
      dl[i] = d[i] - c[i];
      dist2 += uwide_t'(dl[i] * dl[i]);
    end
    rsum = wide_t'(p.rc) + wide_t'(p.rs);
    if (dist2 > uwide_t'(rsum * rsum)) return res;
    len = floor_root(dist2);
    if (dist2 > len * len + len) len++;
    if (dist2 != 0) begin
      unit_of(dl, n);
    end else if (p.h == 0) begin
      n[0] = ONE; n[1] = 0; n[2] = 0;
    end else begin
      // centre on the segment: least-aligned basis axis, made perpendicular
      ref_ax = 0;
      mag = (a[0] < 0) ? -a[0] : a[0];
      if (((a[1] < 0) ? -a[1] : a[1]) < mag) begin
        ref_ax = 1;
        mag = (a[1] < 0) ? -a[1] : a[1];
      end
      if (((a[2] < 0) ? -a[2] : a[2]) < mag) ref_ax = 2;
      for (int i = 0; i < 3; i++)
        perp[i] = ((i == ref_ax) ? wide_t'(ONE) : wide_t'(0))
                  - div_round(a[i] * a[ref_ax], ONE);
      unit_of(perp, n);
    end
    cmax = (wide_t'(1) <<< (CW - 1)) - 1;
    cmin = -cmax - 1;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num = (c[i] + d[i]) * ONE + n[i] * (wide_t'(p.rc) - wide_t'(p.rs));
      v = div_round(num, 2 * ONE);
      if (v > cmax) begin v = cmax; sat = 1'b1; end
      if (v < cmin) begin v = cmin; sat = 1'b1; end
      res.c[i] = v[CW-1:0];
      res.n[i] = p.sf ? -n[i][AW-1:0] : n[i][AW-1:0];
    end
    res.status = sat ? ST_SAT : ST_HIT;
    res.depth = DW'(rsum - wide_t'(len));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    contact_t want;
    if (rst_n && out_strobe) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("report with no pair outstanding", out_status, 0);
      end else begin
        want = pending_contacts.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_contact_x !== want.c[0]) report_mismatch("contact_x", out_contact_x, want.c[0]);
        if (out_contact_y !== want.c[1]) report_mismatch("contact_y", out_contact_y, want.c[1]);
        if (out_contact_z !== want.c[2]) report_mismatch("contact_z", out_contact_z, want.c[2]);
        if (out_normal_x !== want.n[0]) report_mismatch("normal_x", out_normal_x, want.n[0]);
        if (out_normal_y !== want.n[1]) report_mismatch("normal_y", out_normal_y, want.n[1]);
        if (out_normal_z !== want.n[2]) report_mismatch("normal_z", out_normal_z, want.n[2]);
        if (out_depth !== want.depth) report_mismatch("depth", out_depth, want.depth);
      end
    end
  end

  // Watchdog: any transfer in either direction counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", LIMIT);
      $display("** sphere_capsule_contact_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one pair, hold it until the transfer, then book the expectation.
  task automatic send_pair(pair_t p, bit typed, contact_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_offset_x <= p.d[0]; in_offset_y <= p.d[1]; in_offset_z <= p.d[2];
    in_axis_x <= p.a[0]; in_axis_y <= p.a[1]; in_axis_z <= p.a[2];
    in_half_length <= p.h;
    in_capsule_radius <= p.rc;
    in_sphere_radius <= p.rs;
    in_sphere_is_first <= p.sf;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_contacts.push_back(typed ? want : contact_of(p));
  endtask

  function automatic pair_t mk(longint ox, longint oy, longint oz, int ax, int ay, int az,
                               longint h, longint rc, longint rs, bit sf);
    pair_t p;
    p.d[0] = CW'(ox); p.d[1] = CW'(oy); p.d[2] = CW'(oz);
    p.a[0] = AW'(ax); p.a[1] = AW'(ay); p.a[2] = AW'(az);
    p.h = LW'(h); p.rc = LW'(rc); p.rs = LW'(rs); p.sf = sf;
    return p;
  endfunction

  function automatic logic [AW-1:0] rand_axis_comp();
    return AW'(int'($urandom_range(32768)) - int'(ONE));
  endfunction

  // Mostly pairs near contact at a random scale, some full-range noise.
  function automatic pair_t rand_pair();
    pair_t p;
    int sc, kind;
    longint m;
    sc = $urandom_range(3);
    m = (sc == 0) ? 64'hff : (sc == 1) ? 64'hffff : (sc == 2) ? 64'hffffff : 64'h7fffffff;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      p.d[i] = (kind < 15) ? CW'($urandom) : CW'(longint'($urandom) & m);
      if (p.d[i][CW-1] == 1'b0 && $urandom_range(1)) p.d[i] = -p.d[i];
    end
    if (kind >= 15 && kind < 22) p.d = '0;   // centre on the segment
    case ($urandom_range(3))
      0: begin
        p.a = '0;
        p.a[$urandom_range(2)] = $urandom_range(1) ? AW'(ONE) : AW'(-ONE);
      end
      1: begin
        p.a[0] = AW'(int'($urandom_range(ONE / 2)) - int'(ONE / 4));
        p.a[1] = AW'(int'($urandom_range(ONE / 2)) - int'(ONE / 4));
        p.a[2] = $urandom_range(1) ? AW'(ONE - 2000) : AW'(2000 - ONE);
      end
      default: for (int i = 0; i < 3; i++) p.a[i] = rand_axis_comp();
    endcase
    p.h = (kind < 15) ? LW'($urandom) : LW'(longint'($urandom) & m);
    if ($urandom_range(9) == 0) p.h = '0;
    p.rc = (kind < 15) ? LW'($urandom) : LW'(longint'($urandom) & m);
    p.rs = (kind < 15) ? LW'($urandom) : LW'(longint'($urandom) & m);
    p.sf = $urandom_range(1);
    return p;
  endfunction

  row_t rows[$];

  initial begin
    row_t r;
    contact_t none;
    longint big, maxc, minc;
    int phase_items;
    none.status = ST_NONE; none.c = '0; none.n = '0; none.depth = '0;
    big = (longint'(1) << LW) - 1;
    maxc = (longint'(1) << (CW - 1)) - 1;
    minc = -maxc - 1;

    // all zero: touching at the centre, zero segment gives +x
    r.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0); r.typed = 1; r.want = none;
    r.want.status = ST_HIT; r.want.n[0] = AW'(ONE); rows.push_back(r);
    // same with the sphere first: normal flips
    r.p.sf = 1'b1; r.want.n[0] = AW'(-ONE); rows.push_back(r);
    // clearly apart with zero radii
    r.p = mk(1000 <<< 16, 0, 0, ONE, 0, 0, 0, 0, 0, 0); r.want = none; rows.push_back(r);
    r.p = mk(0, minc, 0, 0, 0, ONE, 0, 0, 0, 1); rows.push_back(r);
    r.typed = 0;
    // centre on the segment, nonzero length: perpendicular fallback
    r.p = mk(0, 0, 0, ONE, 0, 0, 5 <<< 16, 1 <<< 16, 1 <<< 16, 0); rows.push_back(r);
    r.p = mk(0, 0, 0, 9000, 9000, 9000, 100, 7, 3, 1); rows.push_back(r);
    r.p = mk(0, 0, 0, 0, 0, ONE, 1, 0, 0, 0); rows.push_back(r);
    // centre on the segment with a degenerate zero axis: the fallback is the x basis axis
    r.p = mk(0, 0, 0, 0, 0, 0, big, big, big, 0); rows.push_back(r);
    // offset extremes against huge radii
    r.p = mk(maxc, maxc, maxc, ONE, 0, 0, 0, big, 0, 0); rows.push_back(r);
    r.p = mk(minc, minc, minc, -ONE, -ONE, -ONE, big, big, big, 1); rows.push_back(r);
    r.p = mk(maxc, minc, maxc, 0, -ONE, 0, big, 0, big, 0); rows.push_back(r);
    // projection beyond the end cap, and inside the segment
    r.p = mk(50 <<< 16, 1 <<< 16, 0, ONE, 0, 0, 10 <<< 16, 1 <<< 16, 41 <<< 16, 0);
    rows.push_back(r);
    r.p = mk(-3 <<< 16, 2 <<< 16, 0, ONE, 0, 0, 10 <<< 16, 1 <<< 16, 2 <<< 16, 1);
    rows.push_back(r);
    // axis not of unit length
    r.p = mk(7 <<< 16, 3 <<< 16, -1 <<< 16, 100, -200, 300, 4 <<< 16, 5 <<< 16, 4 <<< 16, 0);
    rows.push_back(r);
    r.p = mk(-1, 1, -1, ONE, ONE, -ONE, 3, big, 1, 1); rows.push_back(r);
    // exact touch, then moved one unit sideways: just apart
    r.p = mk(3 <<< 16, 0, 0, 0, ONE, 0, 0, 1 <<< 16, 2 <<< 16, 0); rows.push_back(r);
    r.p = mk(3 <<< 16, 1, 0, 0, ONE, 0, 0, 1 <<< 16, 2 <<< 16, 0); rows.push_back(r);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].want);

    // random traffic in three idling regimes, the last with no gaps at all
    phase_items = 470;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 38 : (ph == 1) ? 53 : 0;
      repeat (phase_items) send_pair(rand_pair(), 0, none);
    end
    start <= 1'b0;

    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("** sphere_capsule_contact_top: PASSED **");
    end else begin
      $display("** sphere_capsule_contact_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sccon_pkg.sv
design/sccon_front.sv
design/sccon_fifo.sv
design/sccon_back.sv
design/sphere_capsule_contact_top.sv
verif/tb.sv
